@@ hw/rtl/partition_allocator_ff_bf_wf_defines.svh @@
// Assertion macros shared by the checker of the partition allocator.
`ifndef PARTITION_ALLOCATOR_FF_BF_WF_DEFINES_SVH
`define PARTITION_ALLOCATOR_FF_BF_WF_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAFB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("partition allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define PAFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("partition allocator check failed");

`endif

@@ hw/rtl/pafb_pkg.sv @@
// Types and constants of the partition allocator.
package pafb_pkg;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] REG_POLICY   = 2'd0;
    localparam logic [1:0] REG_MEM_SIZE = 2'd1;
    localparam logic [1:0] REG_MIN_FRAG = 2'd2;

    localparam logic [1:0]  RST_POLICY   = 2'd0;
    localparam logic [15:0] RST_MEM_SIZE = 16'd1024;
    localparam logic [15:0] RST_MIN_FRAG = 16'd10;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_sts;

endpackage

@@ hw/rtl/pafb_ctrl.sv @@
// Controller state machine of the partition allocator.
module pafb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  pafb_pkg::t_sts   i_sts,
    output pafb_pkg::t_cmd   o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);

    pafb_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            pafb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pafb_pkg::S_SCAN;
                end
            end
            pafb_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = pafb_pkg::S_UPD;
            end
            pafb_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = pafb_pkg::S_OUT;
            end
            pafb_pkg::S_OUT: begin
                if (i_out_ready) n_state = pafb_pkg::S_IDLE;
            end
            default: n_state = pafb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pafb_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == pafb_pkg::S_IDLE);
    assign o_out_valid = (r_state == pafb_pkg::S_OUT);

endmodule

@@ hw/rtl/pafb_dp.sv @@
// Datapath of the partition allocator: free table, scan and update logic.
module pafb_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pafb_pkg::t_cmd       i_cmd,
    output pafb_pkg::t_sts       o_sts,
    input  logic [1:0]           i_op,
    input  logic [15:0]          i_req,
    input  logic [15:0]          i_start,
    input  logic [1:0]           i_policy,
    input  logic [15:0]          i_mem_size,
    input  logic [15:0]          i_min_frag,
    output logic [1:0]           o_status,
    output logic [15:0]          o_gaddr,
    output logic [15:0]          o_gsize
);

    localparam int AW = ADDR_BITS;
    localparam int EW = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [EW-1:0] AMASK_E = {{(EW-AW){1'b0}}, {AW{1'b1}}};
    localparam logic [EW-1:0] RST_LEN_E =
        ({{(EW-16){1'b0}}, pafb_pkg::RST_MEM_SIZE} > AMASK_E) ? AMASK_E
        : {{(EW-16){1'b0}}, pafb_pkg::RST_MEM_SIZE};

    logic [AW-1:0] r_fs [TABLE_ENTRIES];
    logic [AW-1:0] r_fl [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_fv;
    logic [TABLE_ENTRIES-1:0] n_fv;

    logic [1:0]    r_op;
    logic [15:0]   r_req;
    logic [AW-1:0] r_s;
    logic [IW-1:0] r_idx;

    logic          r_pk_hit, r_l_hit, r_r_hit, r_e_hit;
    logic [IW-1:0] r_pk_idx, r_l_idx, r_r_idx, r_e_idx;
    logic [AW-1:0] r_pk_s, r_pk_l, r_l_s, r_r_s, r_r_l;

    logic [1:0]    r_status;
    logic [AW-1:0] r_gaddr, r_gsize;

    logic [EW-1:0] req_e, s_e, end_e, start_in_e, mem_e, clr_len_e;
    logic [AW-1:0] cur_s, cur_l;
    logic          cur_v, fit, better, take_pick, left_c, right_c, empty_c;

    logic          wa_en, wa_valid, inv_en;
    logic [IW-1:0] wa_idx, inv_idx;
    logic [AW-1:0] wa_s, wa_l;
    logic [1:0]    n_status;
    logic [AW-1:0] n_gaddr, n_gsize;
    logic [EW-1:0] rem_e, sum_e, ga_e, gs_e;

    function automatic logic [EW-1:0] ext(input logic [AW-1:0] x);
        ext = {{(EW-AW){1'b0}}, x};
    endfunction

    assign req_e      = {{(EW-16){1'b0}}, r_req};
    assign s_e        = ext(r_s);
    assign end_e      = s_e + req_e;
    assign start_in_e = {{(EW-16){1'b0}}, i_start};
    assign mem_e      = {{(EW-16){1'b0}}, i_mem_size};
    assign clr_len_e  = (mem_e > AMASK_E) ? AMASK_E : mem_e;

    assign o_sts.scan_last = (r_idx == IW'(TABLE_ENTRIES - 1));

    // One table entry is examined per scan cycle against the running candidates.
    always_comb begin
        cur_v = r_fv[r_idx];
        cur_s = r_fs[r_idx];
        cur_l = r_fl[r_idx];
        fit   = ext(cur_l) >= req_e;
        case (i_policy)
            pafb_pkg::POL_BEST:
                better = (cur_l != r_pk_l) ? (cur_l < r_pk_l) : (cur_s < r_pk_s);
            pafb_pkg::POL_WORST:
                better = (cur_l != r_pk_l) ? (cur_l > r_pk_l) : (cur_s < r_pk_s);
            default: better = cur_s < r_pk_s;
        endcase
        take_pick = cur_v && fit && (!r_pk_hit || better);
        left_c    = cur_v && !r_l_hit && ((ext(cur_s) + ext(cur_l)) == s_e);
        right_c   = cur_v && !left_c && !r_r_hit && (ext(cur_s) == end_e);
        empty_c   = !cur_v && !r_e_hit;
    end

    always_comb begin
        wa_en    = 1'b0;
        wa_valid = 1'b1;
        wa_idx   = r_pk_idx;
        wa_s     = r_pk_s;
        wa_l     = r_pk_l;
        inv_en   = 1'b0;
        inv_idx  = r_pk_idx;
        n_status = pafb_pkg::ST_OK;
        n_gaddr  = '0;
        n_gsize  = '0;
        rem_e    = ext(r_pk_l) - req_e;
        sum_e    = ext(r_r_s) + ext(r_r_l);
        case (r_op)
            pafb_pkg::OP_ALLOC: begin
                if (r_req == '0) begin
                    n_status = pafb_pkg::ST_ZERO;
                end else if (!r_pk_hit) begin
                    n_status = pafb_pkg::ST_NOFIT;
                end else begin
                    n_gaddr = r_pk_s;
                    if (rem_e > {{(EW-16){1'b0}}, i_min_frag}) begin
                        n_gsize = req_e[AW-1:0];
                        wa_en   = 1'b1;
                        wa_s    = r_pk_s + req_e[AW-1:0];
                        wa_l    = rem_e[AW-1:0];
                    end else begin
                        n_gsize = r_pk_l;
                        inv_en  = 1'b1;
                    end
                end
            end
            pafb_pkg::OP_FREE: begin
                if (r_req == '0) begin
                    n_status = pafb_pkg::ST_ZERO;
                end else if (end_e > AMASK_E) begin
                    n_status = pafb_pkg::ST_NOFIT;
                end else if (r_l_hit) begin
                    wa_en  = 1'b1;
                    wa_idx = r_l_idx;
                    wa_s   = r_l_s;
                    if (r_r_hit) begin
                        wa_l    = sum_e[AW-1:0] - r_l_s;
                        inv_en  = 1'b1;
                        inv_idx = r_r_idx;
                    end else begin
                        wa_l = end_e[AW-1:0] - r_l_s;
                    end
                end else if (r_r_hit) begin
                    wa_en  = 1'b1;
                    wa_idx = r_r_idx;
                    wa_s   = r_s;
                    wa_l   = sum_e[AW-1:0] - r_s;
                end else if (r_e_hit) begin
                    wa_en  = 1'b1;
                    wa_idx = r_e_idx;
                    wa_s   = r_s;
                    wa_l   = req_e[AW-1:0];
                end else begin
                    n_status = pafb_pkg::ST_FULL;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_fv = r_fv;
        if (r_op == pafb_pkg::OP_CLEAR) begin
            n_fv = {{(TABLE_ENTRIES-1){1'b0}}, (clr_len_e != '0)};
        end else begin
            if (wa_en)  n_fv[wa_idx]  = wa_valid;
            if (inv_en) n_fv[inv_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= {{(TABLE_ENTRIES-1){1'b0}}, (RST_LEN_E != '0)};
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_fs[k] <= '0;
                r_fl[k] <= (k == 0) ? RST_LEN_E[AW-1:0] : '0;
            end
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) r_idx <= '0;
            else if (i_cmd.scan && !o_sts.scan_last) r_idx <= r_idx + 1'b1;
            if (i_cmd.update) begin
                r_fv <= n_fv;
                if (r_op == pafb_pkg::OP_CLEAR) begin
                    r_fs[0] <= '0;
                    r_fl[0] <= clr_len_e[AW-1:0];
                end else if (wa_en) begin
                    r_fs[wa_idx] <= wa_s;
                    r_fl[wa_idx] <= wa_l;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_hit <= 1'b0;
            r_l_hit  <= 1'b0;
            r_r_hit  <= 1'b0;
            r_e_hit  <= 1'b0;
        end else if (i_cmd.load) begin
            r_pk_hit <= 1'b0;
            r_l_hit  <= 1'b0;
            r_r_hit  <= 1'b0;
            r_e_hit  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (take_pick) r_pk_hit <= 1'b1;
            if (left_c)    r_l_hit  <= 1'b1;
            if (right_c)   r_r_hit  <= 1'b1;
            if (empty_c)   r_e_hit  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_req <= i_req;
            r_s   <= start_in_e[AW-1:0];
        end
        if (i_cmd.scan) begin
            if (take_pick) begin
                r_pk_idx <= r_idx;
                r_pk_s   <= cur_s;
                r_pk_l   <= cur_l;
            end
            if (left_c) begin
                r_l_idx <= r_idx;
                r_l_s   <= cur_s;
            end
            if (right_c) begin
                r_r_idx <= r_idx;
                r_r_s   <= cur_s;
                r_r_l   <= cur_l;
            end
            if (empty_c) r_e_idx <= r_idx;
        end
        if (i_cmd.update) begin
            r_status <= n_status;
            r_gaddr  <= n_gaddr;
            r_gsize  <= n_gsize;
        end
    end

    assign ga_e     = ext(r_gaddr);
    assign gs_e     = ext(r_gsize);
    assign o_status = r_status;
    assign o_gaddr  = ga_e[15:0];
    assign o_gsize  = gs_e[15:0];

endmodule

@@ hw/rtl/partition_allocator_ff_bf_wf.sv @@
// One transaction is handled at a time: the request is loaded, the table is scanned
// one entry per cycle, the table is updated and the result is offered. The next request
// is accepted in the cycle after the result is taken.
// Synchronous active-low reset: one free block of 1024 units at address 0,
// policy first fit, minimum fragment 10.
module partition_allocator_ff_bf_wf #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_size[15:0], block_start[31:16]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // grant_addr[15:0], grant_size[31:16]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  r_policy;
    logic [15:0] r_mem_size;
    logic [15:0] r_min_frag;
    logic [1:0]  reg_idx;
    logic [15:0] gaddr, gsize;

    pafb_pkg::t_cmd cmd;
    pafb_pkg::t_sts sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= pafb_pkg::RST_POLICY;
            r_mem_size <= pafb_pkg::RST_MEM_SIZE;
            r_min_frag <= pafb_pkg::RST_MIN_FRAG;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                pafb_pkg::REG_POLICY:   r_policy   <= pwdata[1:0];
                pafb_pkg::REG_MEM_SIZE: r_mem_size <= pwdata[15:0];
                pafb_pkg::REG_MIN_FRAG: r_min_frag <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pafb_pkg::REG_POLICY:   prdata = {30'd0, r_policy};
            pafb_pkg::REG_MEM_SIZE: prdata = {16'd0, r_mem_size};
            pafb_pkg::REG_MIN_FRAG: prdata = {16'd0, r_min_frag};
            default:                prdata = '0;
        endcase
    end

    pafb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    pafb_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_op       (s_axis_tuser),
        .i_req      (s_axis_tdata[15:0]),
        .i_start    (s_axis_tdata[31:16]),
        .i_policy   (r_policy),
        .i_mem_size (r_mem_size),
        .i_min_frag (r_min_frag),
        .o_status   (m_axis_tuser),
        .o_gaddr    (gaddr),
        .o_gsize    (gsize)
    );

    assign m_axis_tdata = {gsize, gaddr};

endmodule

@@ hw/rtl/pafb_checker.sv @@
// Port-level checker of the partition allocator and its bind statement.
`include "partition_allocator_ff_bf_wf_defines.svh"

module pafb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        pready
);

    // A result that is waiting keeps its value until it is taken.
    `PAFB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // No new request is taken while a result is still on offer.
    `PAFB_ASSERT_IMPL(a_one_at_a_time, m_axis_tvalid, !s_axis_tready)
    // A failed request never reports a grant.
    `PAFB_ASSERT_IMPL(a_fail_no_grant, m_axis_tvalid && (m_axis_tuser != pafb_pkg::ST_OK), m_axis_tdata == 32'd0)
    // The register port never waits.
    `PAFB_ASSERT_IMPL(a_pready, 1'b1, pready)

endmodule

bind partition_allocator_ff_bf_wf pafb_checker u_pafb_checker (.*);

@@ dv/tb_partition_allocator_ff_bf_wf_checker.sv @@
// Checker for the partition allocator: predicts every result and compares it.
`timescale 1ns / 100ps
module tb_partition_allocator_ff_bf_wf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,   // req_size[15:0], block_start[31:16]
    input  logic [1:0]  i_req_user,   // op[1:0]
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,   // grant_addr[15:0], grant_size[31:16]
    input  logic [1:0]  i_rsp_user,   // status[1:0]
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_pending,
    output int          o_errors
);
    localparam int ENTRIES = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
        logic [15:0] size;
    } t_grant;

    logic [1:0]  cur_policy;
    logic [15:0] cur_mem_size;
    logic [15:0] cur_min_frag;
    logic [15:0] blk_start [ENTRIES];
    logic [15:0] blk_len   [ENTRIES];
    logic        blk_valid [ENTRIES];
    t_grant      grants_due[$];
    int          errors;

    assign o_pending = grants_due.size();
    assign o_errors  = errors;

    task automatic reload_table();
        for (int i = 0; i < ENTRIES; i++) begin
            blk_start[i] = '0;
            blk_len[i]   = '0;
            blk_valid[i] = 1'b0;
        end
        if (cur_mem_size != 0) begin
            blk_len[0]   = cur_mem_size;
            blk_valid[0] = 1'b1;
        end
    endtask

    function automatic bit beats(int cand, int best);
        if (best < 0) return 1'b1;
        if (cur_policy == pafb_pkg::POL_BEST && blk_len[cand] != blk_len[best])
            return blk_len[cand] < blk_len[best];
        if (cur_policy == pafb_pkg::POL_WORST && blk_len[cand] != blk_len[best])
            return blk_len[cand] > blk_len[best];
        return blk_start[cand] < blk_start[best];
    endfunction

    task automatic allocate(input logic [15:0] req, output t_grant g);
        int          pick;
        logic [15:0] rem;
        pick = -1;
        g = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (blk_valid[i] && blk_len[i] >= req && beats(i, pick)) pick = i;
        if (pick < 0) begin
            g.status = pafb_pkg::ST_NOFIT;
            return;
        end
        g.status = pafb_pkg::ST_OK;
        g.addr   = blk_start[pick];
        rem      = blk_len[pick] - req;
        if (rem > cur_min_frag) begin
            g.size          = req;
            blk_start[pick] = blk_start[pick] + req;
            blk_len[pick]   = rem;
        end else begin
            g.size          = blk_len[pick];
            blk_valid[pick] = 1'b0;
            blk_start[pick] = '0;
            blk_len[pick]   = '0;
        end
    endtask

    task automatic release_block(input logic [15:0] s, input logic [15:0] len,
                                 output logic [1:0] status);
        logic [16:0] stop;
        int          lft;
        int          rgt;
        int          hole;
        stop = {1'b0, s} + {1'b0, len};
        lft = -1;
        rgt = -1;
        hole = -1;
        status = pafb_pkg::ST_OK;
        if (stop > 17'hFFFF) begin
            status = pafb_pkg::ST_NOFIT;
            return;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!blk_valid[i]) begin
                if (hole < 0) hole = i;
            end else if (lft < 0 && {1'b0, blk_start[i]} + blk_len[i] == {1'b0, s}) begin
                lft = i;
            end else if (rgt < 0 && {1'b0, blk_start[i]} == stop) begin
                rgt = i;
            end
        end
        if (lft >= 0 && rgt >= 0) begin
            blk_len[lft]   = blk_start[rgt] + blk_len[rgt] - blk_start[lft];
            blk_valid[rgt] = 1'b0;
            blk_start[rgt] = '0;
            blk_len[rgt]   = '0;
        end else if (lft >= 0) begin
            blk_len[lft] = stop[15:0] - blk_start[lft];
        end else if (rgt >= 0) begin
            blk_len[rgt]   = blk_start[rgt] + blk_len[rgt] - s;
            blk_start[rgt] = s;
        end else if (hole >= 0) begin
            blk_start[hole] = s;
            blk_len[hole]   = len;
            blk_valid[hole] = 1'b1;
        end else begin
            status = pafb_pkg::ST_FULL;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_grant g;
        t_grant want;
        if (!i_rst_n) begin
            cur_policy   = pafb_pkg::RST_POLICY;
            cur_mem_size = pafb_pkg::RST_MEM_SIZE;
            cur_min_frag = pafb_pkg::RST_MIN_FRAG;
            reload_table();
            grants_due.delete();
            errors = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    pafb_pkg::REG_POLICY:   cur_policy   = i_pwdata[1:0];
                    pafb_pkg::REG_MEM_SIZE: cur_mem_size = i_pwdata[15:0];
                    pafb_pkg::REG_MIN_FRAG: cur_min_frag = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                g = '0;
                case (i_req_user)
                    pafb_pkg::OP_ALLOC:
                        if (i_req_data[15:0] == 0) g.status = pafb_pkg::ST_ZERO;
                        else allocate(i_req_data[15:0], g);
                    pafb_pkg::OP_FREE:
                        if (i_req_data[15:0] == 0) g.status = pafb_pkg::ST_ZERO;
                        else release_block(i_req_data[31:16], i_req_data[15:0], g.status);
                    pafb_pkg::OP_CLEAR: reload_table();
                    default: ;
                endcase
                grants_due.push_back(g);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (grants_due.size() == 0) begin
                    report_mismatch("unexpected result", i_rsp_data[15:0], 16'd0);
                end else begin
                    want = grants_due.pop_front();
                    if (i_rsp_user != want.status)
                        report_mismatch("status", {14'd0, i_rsp_user}, {14'd0, want.status});
                    if (i_rsp_data[15:0] != want.addr)
                        report_mismatch("grant_addr", i_rsp_data[15:0], want.addr);
                    if (i_rsp_data[31:16] != want.size)
                        report_mismatch("grant_size", i_rsp_data[31:16], want.size);
                end
            end
        end
    end
endmodule

@@ dv/tb_partition_allocator_ff_bf_wf.sv @@
// Testbench top of the partition allocator: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_partition_allocator_ff_bf_wf;

    localparam int STALL_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // req_size[15:0], block_start[31:16]
    logic [1:0]  s_axis_tuser;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // grant_addr[15:0], grant_size[31:16]
    logic [1:0]  m_axis_tuser;   // status[1:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    logic [31:0] held_blocks[$];   // size[31:16], addr[15:0] of live grants

    partition_allocator_ff_bf_wf u_top (.*);

    tb_partition_allocator_ff_bf_wf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_rsp_data(m_axis_tdata), .i_rsp_user(m_axis_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Granted blocks are remembered so that most frees return real allocations.
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready && m_axis_tuser == pafb_pkg::ST_OK
                && m_axis_tdata[31:16] != 0)
            held_blocks.push_back({m_axis_tdata[31:16], m_axis_tdata[15:0]});

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(input logic [1:0] op, input logic [15:0] req, input logic [15:0] s);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {s, req};
        if (op == pafb_pkg::OP_CLEAR) held_blocks.delete();
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_item(input logic [15:0] span);
        int          pick;
        logic [31:0] blk;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            if ($urandom_range(9) == 0)
                send(pafb_pkg::OP_ALLOC, 16'($urandom), 16'($urandom));
            else
                send(pafb_pkg::OP_ALLOC, 16'($urandom_range(1, span)), 16'($urandom));
        end else if (roll < 82 && held_blocks.size() != 0) begin
            pick = $urandom_range(held_blocks.size() - 1);
            blk = held_blocks[pick];
            held_blocks.delete(pick);
            send(pafb_pkg::OP_FREE, blk[31:16], blk[15:0]);
        end else if (roll < 88) begin
            send(pafb_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
        end else begin
            send(2'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = pafb_pkg::OP_ALLOC;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 33;
        recv_stall_pct = 83;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset settings.
        send(pafb_pkg::OP_ALLOC, 16'd0, 16'hFFFF);
        send(pafb_pkg::OP_FREE, 16'd0, 16'd100);
        send(2'd3, 16'hFFFF, 16'hFFFF);
        send(pafb_pkg::OP_ALLOC, 16'hFFFF, 16'd0);
        send(pafb_pkg::OP_FREE, 16'd1, 16'hFFFF);
        send(pafb_pkg::OP_FREE, 16'd5, 16'hFFFA);
        // Isolated frees fill the table; the last one finds no room.
        for (int k = 0; k < 15; k++)
            send(pafb_pkg::OP_FREE, 16'd10, 16'(2000 + 100 * k));
        send(pafb_pkg::OP_CLEAR, 16'd0, 16'd0);
        send(pafb_pkg::OP_ALLOC, 16'd1024, 16'd0);
        send(pafb_pkg::OP_ALLOC, 16'd1, 16'd0);
        send(pafb_pkg::OP_CLEAR, 16'd0, 16'd0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    reg_write(pafb_pkg::REG_POLICY, 32'(pafb_pkg::POL_BEST));
                    reg_write(pafb_pkg::REG_MEM_SIZE, 32'd65535);
                    reg_write(pafb_pkg::REG_MIN_FRAG, 32'd0);
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 33;
                    reg_write(pafb_pkg::REG_POLICY, 32'(pafb_pkg::POL_WORST));
                    reg_write(pafb_pkg::REG_MEM_SIZE, 32'd1);
                    reg_write(pafb_pkg::REG_MIN_FRAG, 32'd65535);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    reg_write(pafb_pkg::REG_POLICY, 32'd3);
                    reg_write(pafb_pkg::REG_MEM_SIZE, 32'd1024);
                    reg_write(pafb_pkg::REG_MIN_FRAG, 32'd10);
                end
                default: begin
                    reg_write(pafb_pkg::REG_POLICY, 32'(pafb_pkg::POL_FIRST));
                    reg_write(pafb_pkg::REG_MEM_SIZE, 32'd4000);
                    reg_write(pafb_pkg::REG_MIN_FRAG, 32'd3);
                end
            endcase
            send(pafb_pkg::OP_CLEAR, 16'd0, 16'd0);
            for (int n = 0; n < 137; n++) begin
                random_item(phase == 0 ? 16'd4000 : 16'd300);
                if (n == 60) begin
                    s_axis_tvalid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
